### rtl/hmf_pkg.sv
// shared types and constants for the histogram mode filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package hmf_pkg;

  localparam int CENTRE_W = 9;
  localparam int WIN_W    = 21;
  localparam int SAMPLE_W = 16;
  localparam int RADIUS_W = 4;
  localparam int SCAN_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BELOW_BIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ABOVE_BIN = 3'd4;

  localparam logic [CENTRE_W-1:0] MIN_RANGE_RST = 9'd20;
  localparam logic [CENTRE_W-1:0] MAX_RANGE_RST = 9'd350;
  localparam logic [RADIUS_W-1:0] RADIUS_RST    = 4'd2;
  localparam logic [CENTRE_W-1:0] BELOW_BIN_RST = 9'd0;
  localparam logic [CENTRE_W-1:0] ABOVE_BIN_RST = 9'd351;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUMP,
    ST_SCAN,
    ST_WAIT1,
    ST_WAIT2,
    ST_EMIT
  } state_t;

  // control from the scan sequencer to the window datapath
  typedef struct packed {
    logic                start;
    logic                valid;
    logic                eval;
    logic [CENTRE_W-1:0] centre;
  } win_ctl_t;

endpackage

`default_nettype wire

### rtl/hmf_window.sv
// sliding window sum over histogram bins read in order, with best centre tracking
// depends on hmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module hmf_window #(
  parameter int MAX_RADIUS  = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  hmf_pkg::win_ctl_t             ctl,
  input  wire [COUNT_WIDTH-1:0]         bin_data,
  input  wire [hmf_pkg::RADIUS_W-1:0]   radius,
  output logic [hmf_pkg::CENTRE_W-1:0]  best_centre,
  output logic [hmf_pkg::WIN_W-1:0]     best_window
);
  import hmf_pkg::*;

  localparam int TAPS  = 2 * MAX_RADIUS + 1;
  localparam int SUM_W = COUNT_WIDTH + $clog2(TAPS + 1);
  localparam int CMP_W = (SUM_W > WIN_W) ? SUM_W : WIN_W;

  logic [COUNT_WIDTH-1:0] taps [TAPS];
  logic [SUM_W-1:0]       sum;
  logic                   eval;
  logic [CENTRE_W-1:0]    eval_centre;
  logic [COUNT_WIDTH-1:0] best_count;

  logic [COUNT_WIDTH-1:0] drop;
  logic [COUNT_WIDTH-1:0] own;
  logic [CMP_W-1:0]       sum_ext;
  logic [WIN_W-1:0]       win_sat;
  logic                   take;

  // bin leaving the window is the one 2r+1 places back
  always_comb begin
    drop = '0;
    for (int k = 0; k < TAPS; k++) begin
      if (k == 2 * int'(radius)) drop = taps[k];
    end
  end

  always_comb begin
    own = '0;
    for (int k = 0; k <= MAX_RADIUS; k++) begin
      if (k == int'(radius)) own = taps[k];
    end
  end

  assign sum_ext = CMP_W'(sum);
  assign win_sat = (sum_ext > CMP_W'(WIN_MAX)) ? WIN_MAX : WIN_W'(sum_ext);
  assign take    = eval && ((win_sat > best_window) ||
                            ((win_sat == best_window) && (own > best_count)));

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int k = 0; k < TAPS; k++) taps[k] <= '0;
      sum <= '0;
    end else if (ctl.valid) begin
      taps[0] <= bin_data;
      for (int k = 1; k < TAPS; k++) taps[k] <= taps[k-1];
      sum <= sum + SUM_W'(bin_data) - SUM_W'(drop);
    end
    eval_centre <= ctl.centre;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval        <= 1'b0;
      best_centre <= '0;
      best_window <= '0;
      best_count  <= '0;
    end else begin
      eval <= ctl.valid && ctl.eval;
      if (ctl.start) begin
        best_centre <= '0;
        best_window <= '0;
        best_count  <= '0;
      end else if (take) begin
        best_centre <= eval_centre;
        best_window <= win_sat;
        best_count  <= own;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/histogram_mode_filter_neighbors.sv
// histogram mode filter: per-sample bin update by read-modify-write, then window scan
// sample: each beat is a read, then a write back; busy during the write back
// last sample: scan of max_range + r + 1 reads, result after WAIT1, WAIT2 and EMIT,
// then a clearing sweep of all BIN_COUNT bins before the next sample is taken
// reset: registers to their defaults, then the same clearing sweep
// done is a one-cycle strobe; config writes are always taken (cfg_ready high)
`timescale 1ns / 1ps
`default_nettype none

module histogram_mode_filter_neighbors #(
  parameter int BIN_COUNT   = 512,
  parameter int MAX_RADIUS  = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire [hmf_pkg::SAMPLE_W-1:0]      sample,
  input  wire                              last_sample,
  output logic                             done,
  output logic [hmf_pkg::CENTRE_W-1:0]     filtered_range,
  output logic [hmf_pkg::WIN_W-1:0]        window_total,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [hmf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [hmf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hmf_pkg::*;

  localparam int AW = $clog2(BIN_COUNT);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  state_t state, state_next;

  logic [CENTRE_W-1:0] min_range, max_range, below_bin, above_bin;
  logic [RADIUS_W-1:0] neighbor_radius;

  logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
  logic [COUNT_WIDTH-1:0] rdata;
  logic [AW-1:0]          mem_raddr, mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic                   mem_we;

  logic [AW-1:0]     clr_addr;
  logic [SCAN_W-1:0] scan_j;
  logic [AW-1:0]     bump_addr;
  logic              bump_ok;
  logic              bump_last;

  logic              p1_valid, p1_zero, p1_eval;
  logic [CENTRE_W-1:0] p1_centre;

  logic [CENTRE_W-1:0] bin_sel;
  logic                accept;
  logic [RADIUS_W-1:0] r_eff;
  logic [SCAN_W-1:0]   last_j;
  logic                scan_eval;
  logic                scan_zero;

  win_ctl_t            win_ctl;
  logic [COUNT_WIDTH-1:0] win_data;
  logic [CENTRE_W-1:0] best_centre;
  logic [WIN_W-1:0]    best_window;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  // bin for an incoming sample
  always_comb begin
    if ((sample >= SAMPLE_W'(min_range)) && (sample <= SAMPLE_W'(max_range))) begin
      bin_sel = CENTRE_W'(sample);
    end else if (sample < SAMPLE_W'(min_range)) begin
      bin_sel = below_bin;
    end else begin
      bin_sel = above_bin;
    end
  end

  assign r_eff     = (int'(neighbor_radius) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS)
                                                          : neighbor_radius;
  assign last_j    = SCAN_W'(max_range) + SCAN_W'(r_eff);
  assign scan_eval = (scan_j >= (SCAN_W'(r_eff) << 1));
  assign scan_zero = (int'(scan_j) >= BIN_COUNT);

  // config register file
  always_ff @(posedge clk) begin
    if (rst) begin
      min_range       <= MIN_RANGE_RST;
      max_range       <= MAX_RANGE_RST;
      neighbor_radius <= RADIUS_RST;
      below_bin       <= BELOW_BIN_RST;
      above_bin       <= ABOVE_BIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_RANGE: min_range       <= cfg_data;
        CFG_MAX_RANGE: max_range       <= cfg_data;
        CFG_RADIUS:    neighbor_radius <= RADIUS_W'(cfg_data);
        CFG_BELOW_BIN: below_bin       <= cfg_data;
        CFG_ABOVE_BIN: above_bin       <= cfg_data;
        default: ;
      endcase
    end
  end

  // memory port selection
  always_comb begin
    mem_raddr = (state == ST_SCAN) ? AW'(scan_j) : AW'(bin_sel);
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == ST_BUMP) begin
      mem_we    = bump_ok;
      mem_waddr = bump_addr;
      mem_wdata = (rdata == COUNT_MAX) ? rdata : rdata + COUNT_WIDTH'(1);
    end else if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (int'(clr_addr) == BIN_COUNT - 1) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_BUMP;
      ST_BUMP:  state_next = bump_last ? ST_SCAN : ST_IDLE;
      ST_SCAN:  if (scan_j == last_j) state_next = ST_WAIT1;
      ST_WAIT1: state_next = ST_WAIT2;
      ST_WAIT2: state_next = ST_EMIT;
      ST_EMIT:  state_next = ST_CLEAR;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      scan_j   <= '0;
      p1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= (state == ST_SCAN);
      done     <= (state == ST_EMIT);
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      else                   clr_addr <= '0;
      if (state == ST_SCAN) scan_j <= scan_j + SCAN_W'(1);
      else                  scan_j <= '0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      bump_addr <= AW'(bin_sel);
      bump_ok   <= (int'(bin_sel) < BIN_COUNT);
      bump_last <= last_sample;
    end
    p1_zero   <= scan_zero;
    p1_eval   <= scan_eval;
    p1_centre <= CENTRE_W'(scan_j - SCAN_W'(r_eff));
    if (state == ST_EMIT) begin
      filtered_range <= best_centre;
      window_total   <= best_window;
    end
  end

  // bins past the end of the histogram read as zero
  assign win_data       = p1_zero ? '0 : rdata;
  assign win_ctl.start  = (state == ST_BUMP) && bump_last;
  assign win_ctl.valid  = p1_valid;
  assign win_ctl.eval   = p1_eval;
  assign win_ctl.centre = p1_centre;

  hmf_window #(
    .MAX_RADIUS  (MAX_RADIUS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .ctl         (win_ctl),
    .bin_data    (win_data),
    .radius      (r_eff),
    .best_centre (best_centre),
    .best_window (best_window)
  );

endmodule

`default_nettype wire

### rtl/hmf_checker.sv
// port-level checks on the histogram mode filter, bound to the top level
// depends on hmf_pkg and histogram_mode_filter_neighbors
`timescale 1ns / 1ps
`default_nettype none

module hmf_checker (
  input wire clk,
  input wire rst,
  input wire start,
  input wire busy,
  input wire last_sample,
  input wire done
);
  import hmf_pkg::*;

  // result strobe is a single cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // result only appears while the histogram is being cleared
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done while idle");

  // clearing sweep follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> busy)
    else $error("not busy straight after reset");

  // an ordinary beat is busy for the write back, then idle again
  a_plain_beat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_sample) |=> busy ##1 !busy)
    else $error("ordinary beat did not complete in two cycles");

  // last beat starts a scan, never an instant result
  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_sample) |=> busy && !done ##1 busy && !done)
    else $error("last beat did not start a scan");

endmodule

bind histogram_mode_filter_neighbors hmf_checker u_hmf_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .last_sample (last_sample),
  .done        (done)
);

`default_nettype wire

### bench/histogram_mode_filter_neighbors_test.sv
// self-checking bench for histogram_mode_filter_neighbors: directed and random sample batches
// depends on hmf_pkg and the block; a scoreboard class predicts each batch's mode and window
`timescale 1ns / 1ps
`default_nettype none

module histogram_mode_filter_neighbors_test;

  localparam int BINS         = 512;
  localparam int RADIUS_LIMIT = 8;
  localparam int COUNT_W      = 16;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  logic [hmf_pkg::SAMPLE_W-1:0]     sample = '0;
  logic                             last_sample = 1'b0;
  logic                             done;
  logic [hmf_pkg::CENTRE_W-1:0]     filtered_range;
  logic [hmf_pkg::WIN_W-1:0]        window_total;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [hmf_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [hmf_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  int idle_pct = 0;
  int sent = 0;

  // keeps its own histogram and registers, predicts the mode of each batch
  class mode_scoreboard;
    bit [hmf_pkg::CENTRE_W-1:0] min_r  = hmf_pkg::MIN_RANGE_RST;
    bit [hmf_pkg::CENTRE_W-1:0] max_r  = hmf_pkg::MAX_RANGE_RST;
    bit [hmf_pkg::RADIUS_W-1:0] radius = hmf_pkg::RADIUS_RST;
    bit [hmf_pkg::CENTRE_W-1:0] below  = hmf_pkg::BELOW_BIN_RST;
    bit [hmf_pkg::CENTRE_W-1:0] above  = hmf_pkg::ABOVE_BIN_RST;
    bit [COUNT_W-1:0]           hist [BINS];
    bit [hmf_pkg::CENTRE_W-1:0] centre_q [$];
    bit [hmf_pkg::WIN_W-1:0]    total_q [$];
    int                         errors = 0;

    function int pending();
      return centre_q.size();
    endfunction

    function void write_reg(logic [hmf_pkg::CFG_IDX_W-1:0] idx,
                            logic [hmf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        hmf_pkg::CFG_MIN_RANGE: min_r  = data;
        hmf_pkg::CFG_MAX_RANGE: max_r  = data;
        hmf_pkg::CFG_RADIUS:    radius = data[hmf_pkg::RADIUS_W-1:0];
        hmf_pkg::CFG_BELOW_BIN: below  = data;
        hmf_pkg::CFG_ABOVE_BIN: above  = data;
        default: ;
      endcase
    endfunction

    function void take_sample(bit [hmf_pkg::SAMPLE_W-1:0] s, bit last);
      int                         slot;
      int                         r;
      longint                     win;
      bit [COUNT_W-1:0]           own;
      bit [hmf_pkg::CENTRE_W-1:0] best_c;
      bit [hmf_pkg::WIN_W-1:0]    best_w;
      bit [COUNT_W-1:0]           best_own;
      if (s >= min_r && s <= max_r) slot = s;
      else if (s < min_r) slot = below;
      else slot = above;
      if (slot < BINS && hist[slot] != {COUNT_W{1'b1}}) hist[slot]++;
      if (!last) return;
      r = (radius > RADIUS_LIMIT) ? RADIUS_LIMIT : radius;
      best_c = '0;
      best_w = '0;
      best_own = '0;
      for (int c = r; c <= max_r; c++) begin
        win = 0;
        own = (c < BINS) ? hist[c] : '0;
        for (int j = c - r; j <= c + r; j++) begin
          if (j < BINS) win += hist[j];
        end
        if (win > hmf_pkg::WIN_MAX) win = hmf_pkg::WIN_MAX;
        if (win > best_w || (win == best_w && own > best_own)) begin
          best_c = hmf_pkg::CENTRE_W'(c);
          best_w = hmf_pkg::WIN_W'(win);
          best_own = own;
        end
      end
      centre_q.push_back(best_c);
      total_q.push_back(best_w);
      foreach (hist[i]) hist[i] = '0;
    endfunction

    function void check_result(logic [hmf_pkg::CENTRE_W-1:0] fr,
                               logic [hmf_pkg::WIN_W-1:0] wt);
      bit [hmf_pkg::CENTRE_W-1:0] exp_c;
      bit [hmf_pkg::WIN_W-1:0]    exp_t;
      if (centre_q.size() == 0) begin
        $display("%0t: unexpected result beat, filtered_range %0d window_total %0d",
                 $time, fr, wt);
        errors++;
        return;
      end
      exp_c = centre_q.pop_front();
      exp_t = total_q.pop_front();
      if (fr !== exp_c) begin
        $display("%0t: filtered_range expected %0d actual %0d", $time, exp_c, fr);
        errors++;
      end
      if (wt !== exp_t) begin
        $display("%0t: window_total expected %0d actual %0d", $time, exp_t, wt);
        errors++;
      end
    endfunction
  endclass

  mode_scoreboard sb = new();

  histogram_mode_filter_neighbors uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .sample         (sample),
    .last_sample    (last_sample),
    .done           (done),
    .filtered_range (filtered_range),
    .window_total   (window_total),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(100_000_000);
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(filtered_range, window_total);
  end

  task automatic send_sample(input logic [hmf_pkg::SAMPLE_W-1:0] value, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      // junk on the data lines while start is low
      sample <= hmf_pkg::SAMPLE_W'($urandom);
      last_sample <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    sample <= value;
    last_sample <= last;
    do @(posedge clk); while (busy);
    sb.take_sample(value, last);
    sent++;
  endtask

  // hold off until every mode is out and the clearing sweep is over
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic put_reg(input logic [hmf_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[hmf_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value[hmf_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic configure(input int lo, input int hi, input int rad,
                           input int blw, input int abv);
    settle();
    put_reg(hmf_pkg::CFG_MIN_RANGE, lo);
    put_reg(hmf_pkg::CFG_MAX_RANGE, hi);
    put_reg(hmf_pkg::CFG_RADIUS, rad);
    put_reg(hmf_pkg::CFG_BELOW_BIN, blw);
    put_reg(hmf_pkg::CFG_ABOVE_BIN, abv);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [hmf_pkg::SAMPLE_W-1:0] pick_sample(int mode);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = mode + int'($urandom_range(6)) - 3;
      5, 6: v = (sb.min_r <= sb.max_r) ? int'($urandom_range(sb.max_r, sb.min_r))
                                       : int'($urandom_range(511));
      7: v = ($urandom_range(1) ? int'(sb.min_r) : int'(sb.max_r) + 1)
             - int'($urandom_range(1));
      default: v = $urandom_range(65535);
    endcase
    if (v < 0) v = 0;
    return v[hmf_pkg::SAMPLE_W-1:0];
  endfunction

  initial begin
    int hi;
    int mode;
    int len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: reset settings, both out-of-range bins, range edges
    idle_pct = 11;
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd20, 1'b0);
    send_sample(16'd350, 1'b0);
    send_sample(16'd19, 1'b0);
    send_sample(16'd351, 1'b0);
    send_sample(16'd100, 1'b0);
    send_sample(16'd100, 1'b0);
    send_sample(16'd101, 1'b1);
    // min above max, nothing lands in a scanned bin: empty result
    configure(20, 10, 0, 500, 511);
    send_sample(16'd5, 1'b0);
    send_sample(16'd30, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    // radius larger than max_range: no centre scanned
    configure(0, 3, 8, 0, 1);
    send_sample(16'd0, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'd3, 1'b1);
    // radius beyond its limit gets clamped, windows reaching the top bin
    configure(0, 503, 15, 511, 504);
    send_sample(16'd0, 1'b0);
    send_sample(16'd503, 1'b0);
    send_sample(16'd504, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd250, 1'b0);
    send_sample(16'd250, 1'b1);
    // single centre, above bin folded onto it
    configure(0, 0, 0, 511, 0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'd2, 1'b1);

    // the tie on window sum goes to the bigger own count
    idle_pct = 0;
    configure(0, 503, 1, 0, 504);
    send_sample(16'd299, 1'b0);
    send_sample(16'd300, 1'b0);
    send_sample(16'd301, 1'b0);
    send_sample(16'd301, 1'b0);
    send_sample(16'd302, 1'b1);

    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 11 : (ph == 1) ? 58 : 0;
      while (sent < (ph + 1) * 270) begin
        if ($urandom_range(2) == 0) begin
          case ($urandom_range(7))
            0: configure(0, 503, 8, 0, 511);
            1: configure(511, $urandom_range(503), $urandom_range(15),
                         $urandom_range(511), $urandom_range(511));
            2: configure(0, $urandom_range(20), $urandom_range(15),
                         $urandom_range(511), $urandom_range(511));
            default: begin
              hi = $urandom_range(503);
              configure($urandom_range(hi), hi,
                        ($urandom_range(7) == 0) ? $urandom_range(15, 9) : $urandom_range(8),
                        $urandom_range(511), $urandom_range(511));
            end
          endcase
        end
        mode = (sb.min_r <= sb.max_r) ? $urandom_range(sb.max_r, sb.min_r)
                                      : $urandom_range(511);
        len = ($urandom_range(5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
        for (int i = 0; i < len; i++) send_sample(pick_sample(mode), i == len - 1);
        if ($urandom_range(9) == 0) settle();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
